FILE: rtl/kwat_pkg.sv
// ----------------------------------------------------------------------------
// kwat_pkg
// Shared widths, types and status codes for the keyed weight accumulate table.
// ----------------------------------------------------------------------------
package kwat_pkg;

    localparam int IDX_W    = 32;
    localparam int WT_W     = 32;
    localparam int KEY_W    = IDX_W + 1;
    localparam int ACC_W    = 48;
    localparam int SLOT_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [WT_W-1:0]    wt_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [ACC_W-1:0]   acc_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_UPDATED = 2'd0,
        STATUS_ADDED   = 2'd1,
        STATUS_DROPPED = 2'd2
    } status_t;

    // One result item
    typedef struct packed {
        slot_t   slot;
        acc_t    total_weight;
        count_t  entry_count;
        status_t status;
    } result_t;

endpackage

FILE: rtl/kwat_if.sv
// ----------------------------------------------------------------------------
// kwat_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface kwat_item_if;
    logic              valid;
    logic              ready;
    kwat_pkg::idx_t    item_index;
    logic              is_center;
    kwat_pkg::wt_t     weight;

    modport source (output valid, item_index, is_center, weight, input ready);
    modport sink   (input valid, item_index, is_center, weight, output ready);
endinterface

interface kwat_result_if;
    logic                                 valid;
    logic                                 ready;
    kwat_pkg::slot_t                      slot;
    kwat_pkg::acc_t                       total_weight;
    kwat_pkg::count_t                     entry_count;
    logic [kwat_pkg::STATUS_W-1:0]        status;

    modport source (output valid, slot, total_weight, entry_count, status, input ready);
    modport sink   (input valid, slot, total_weight, entry_count, status, output ready);
endinterface

FILE: rtl/keyed_weight_accumulate_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_weight_accumulate_table_unit
// Associative accumulate table: matches a key against stored keys in
// insertion order and adds a Q16.16 weight into a saturating Q32.16 total.
// ----------------------------------------------------------------------------
// Flow: a key found at slot k is updated in place; a new key is appended,
//   or dropped when the table is full.
// Throughput: one item at a time; the key search runs one slot per cycle
//   through one comparator on the key RAM read port, and the next input is
//   taken only once the previous result has gone to the output register.
// Reset: rst_n clears the entry count, so the table starts empty; RAM
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module keyed_weight_accumulate_table_unit #(
    parameter int CAPACITY = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    kwat_item_if.sink      item_in,
    kwat_result_if.source  result_out
);

    localparam int AW = $clog2(CAPACITY);

    logic                 key_we, key_re, wt_we, wt_re;
    logic [AW-1:0]        key_waddr, key_raddr, wt_waddr, wt_raddr;
    kwat_pkg::key_t       key_wdata, key_rdata;
    kwat_pkg::acc_t       wt_wdata, wt_rdata;
    logic                 res_valid, res_ready;
    kwat_pkg::result_t    res;
    logic                 out_valid_reg;
    kwat_pkg::result_t    out_reg;

    kwat_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .in_index  (item_in.item_index),
        .in_center (item_in.is_center),
        .in_weight (item_in.weight),
        .key_we    (key_we),
        .key_waddr (key_waddr),
        .key_wdata (key_wdata),
        .key_re    (key_re),
        .key_raddr (key_raddr),
        .key_rdata (key_rdata),
        .wt_we     (wt_we),
        .wt_waddr  (wt_waddr),
        .wt_wdata  (wt_wdata),
        .wt_re     (wt_re),
        .wt_raddr  (wt_raddr),
        .wt_rdata  (wt_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    kwat_ram #(
        .WIDTH (kwat_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    kwat_ram #(
        .WIDTH (kwat_pkg::ACC_W),
        .DEPTH (CAPACITY)
    ) u_wt_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wdata),
        .re    (wt_re),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    // Output register: takes a result when empty or being drained
    assign res_ready = !out_valid_reg || result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.slot         = out_reg.slot;
    assign result_out.total_weight = out_reg.total_weight;
    assign result_out.entry_count  = out_reg.entry_count;
    assign result_out.status       = out_reg.status;

endmodule

FILE: rtl/kwat_ram.sv
// ----------------------------------------------------------------------------
// kwat_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kwat_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/kwat_ctrl.sv
// ----------------------------------------------------------------------------
// kwat_ctrl
// Search sequencer: walks the key RAM one slot per cycle through a single
// key comparator, then a saturating read-modify-write on a hit, else append or drop.
// ----------------------------------------------------------------------------
module kwat_ctrl #(
    parameter int CAPACITY = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // input item
    input  logic                      in_valid,
    output logic                      in_ready,
    input  kwat_pkg::idx_t            in_index,
    input  logic                      in_center,
    input  kwat_pkg::wt_t             in_weight,
    // key RAM
    output logic                      key_we,
    output logic [$clog2(CAPACITY)-1:0] key_waddr,
    output kwat_pkg::key_t            key_wdata,
    output logic                      key_re,
    output logic [$clog2(CAPACITY)-1:0] key_raddr,
    input  kwat_pkg::key_t            key_rdata,
    // weight RAM
    output logic                      wt_we,
    output logic [$clog2(CAPACITY)-1:0] wt_waddr,
    output kwat_pkg::acc_t            wt_wdata,
    output logic                      wt_re,
    output logic [$clog2(CAPACITY)-1:0] wt_raddr,
    input  kwat_pkg::acc_t            wt_rdata,
    // result
    output logic                      res_valid,
    input  logic                      res_ready,
    output kwat_pkg::result_t         res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_ADD    = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_idx_reg, pend_idx_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       slot_reg, slot_next;
    kwat_pkg::key_t      key_reg, key_next;
    kwat_pkg::wt_t       wt_reg, wt_next;
    kwat_pkg::result_t   res_reg, res_next;

    logic                issue;
    logic                hit;
    logic [CW-1:0]       count_inc;
    logic [kwat_pkg::ACC_W:0] sum;
    kwat_pkg::acc_t      total_sat;

    // Shared key comparator and saturating adder
    assign issue     = (idx_reg < count_reg);
    assign hit       = pend_reg && (key_rdata == key_reg);
    assign count_inc = count_reg + 1'b1;
    assign sum       = {1'b0, wt_rdata} + {{(kwat_pkg::ACC_W + 1 - kwat_pkg::WT_W){1'b0}}, wt_reg};
    assign total_sat = sum[kwat_pkg::ACC_W] ? {kwat_pkg::ACC_W{1'b1}}
                                            : sum[kwat_pkg::ACC_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        key_next      = key_reg;
        wt_next       = wt_reg;
        res_next      = res_reg;
        key_we        = 1'b0;
        key_waddr     = count_reg[AW-1:0];
        key_wdata     = key_reg;
        key_re        = 1'b0;
        key_raddr     = idx_reg[AW-1:0];
        wt_we         = 1'b0;
        wt_waddr      = count_reg[AW-1:0];
        wt_wdata      = {{(kwat_pkg::ACC_W - kwat_pkg::WT_W){1'b0}}, wt_reg};
        wt_re         = 1'b0;
        wt_raddr      = pend_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next   = {in_center, in_index};
                    wt_next    = in_weight;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                // issue the next key read while comparing the previous one
                key_re        = issue;
                pend_next     = issue;
                pend_idx_next = idx_reg[AW-1:0];
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end

                if (hit)
                begin
                    wt_re      = 1'b1;
                    slot_next  = pend_idx_reg;
                    state_next = ST_ADD;
                end
                else if (!issue)
                begin
                    if (count_reg < CAP_COUNT)
                    begin
                        // append a new entry
                        key_we     = 1'b1;
                        wt_we      = 1'b1;
                        count_next = count_inc;
                        res_next.slot         = kwat_pkg::slot_t'(count_reg[AW-1:0]);
                        res_next.total_weight = wt_wdata;
                        res_next.entry_count  = kwat_pkg::count_t'(count_inc);
                        res_next.status       = kwat_pkg::STATUS_ADDED;
                    end
                    else
                    begin
                        // table full, drop
                        res_next.slot         = '0;
                        res_next.total_weight = '0;
                        res_next.entry_count  = kwat_pkg::count_t'(count_reg);
                        res_next.status       = kwat_pkg::STATUS_DROPPED;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_ADD:
            begin
                wt_we                 = 1'b1;
                wt_waddr              = slot_reg;
                wt_wdata              = total_sat;
                res_next.slot         = kwat_pkg::slot_t'(slot_reg);
                res_next.total_weight = total_sat;
                res_next.entry_count  = kwat_pkg::count_t'(count_reg);
                res_next.status       = kwat_pkg::STATUS_UPDATED;
                state_next            = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        key_reg      <= key_next;
        wt_reg       <= wt_next;
        res_reg      <= res_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count moved by more than one");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_reg.status == kwat_pkg::STATUS_DROPPED)) |->
        (count_reg == CAP_COUNT))
        else $error("item dropped with room left");

    a_append_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |-> ((count_reg < CAP_COUNT) && (key_waddr == count_reg[AW-1:0])))
        else $error("new key written outside the append slot");
`endif

endmodule

FILE: sim/tb_keyed_weight_accumulate_table_unit.sv
// ----------------------------------------------------------------------------
// tb_keyed_weight_accumulate_table_unit
// Self-checking bench for the keyed weight accumulate table. Items go in over
// the item channel with random idle cycles; a scoreboard keeps its own copy of
// the key table and the saturating totals, and checks every result transfer
// field by field. Phases: edge-value keys and weights, a run of max-weight
// adds on slot 0 with no idling, then random traffic from a key pool that
// widens until the table fills and new keys are dropped.
// ----------------------------------------------------------------------------
module tb_keyed_weight_accumulate_table_unit;

    localparam int TABLE_DEPTH  = 256;
    localparam int POOL_SIZE    = 400;
    localparam int RANDOM_ITEMS = 1600;
    localparam int SAT_ADDS     = 40;
    localparam int IDLE_PCT     = 23;
    localparam int QUIET_LIMIT  = 4000;

    // Scoreboard: mirror of the key table, expected results in arrival order
    class weight_table_scoreboard #(int DEPTH = 256);
        kwat_pkg::key_t    held_key[DEPTH];
        kwat_pkg::acc_t    held_total[DEPTH];
        int unsigned       held_count;
        kwat_pkg::result_t expected_results[$];
        int unsigned       result_num;
        int unsigned       err_count;

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            err_count++;
        endtask

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        // Accepted item: search in insertion order, then add, append or drop
        function void note_item(input kwat_pkg::idx_t idx, input logic ctr,
                                input kwat_pkg::wt_t wt);
            kwat_pkg::key_t           k;
            int unsigned              pos;
            logic [kwat_pkg::ACC_W:0] sum;
            kwat_pkg::result_t        exp;
            k   = {ctr, idx};
            pos = 0;
            exp = '0;
            while (pos < held_count && held_key[pos] != k)
                pos++;
            if (pos < held_count)
            begin
                sum = {1'b0, held_total[pos]} + wt;
                held_total[pos]  = sum[kwat_pkg::ACC_W] ? '1 : sum[kwat_pkg::ACC_W-1:0];
                exp.slot         = kwat_pkg::slot_t'(pos);
                exp.total_weight = held_total[pos];
                exp.status       = kwat_pkg::STATUS_UPDATED;
            end
            else if (held_count < DEPTH)
            begin
                held_key[held_count]   = k;
                held_total[held_count] = kwat_pkg::acc_t'(wt);
                exp.slot               = kwat_pkg::slot_t'(held_count);
                exp.total_weight       = held_total[held_count];
                exp.status             = kwat_pkg::STATUS_ADDED;
                held_count++;
            end
            else
            begin
                // table full, key new: nothing stored
                exp.status = kwat_pkg::STATUS_DROPPED;
            end
            exp.entry_count = kwat_pkg::count_t'(held_count);
            expected_results = {expected_results, exp};
        endfunction

        task check_result(input kwat_pkg::result_t got);
            kwat_pkg::result_t exp;
            result_num++;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result %0d with none pending: slot %0d total %h count %0d",
                                 result_num, got.slot, got.total_weight, got.entry_count));
                return;
            end
            exp = expected_results.pop_front();
            if (got.slot !== exp.slot)
                report($sformatf("result %0d slot %0d, want %0d",
                                 result_num, got.slot, exp.slot));
            if (got.total_weight !== exp.total_weight)
                report($sformatf("result %0d total_weight %h, want %h",
                                 result_num, got.total_weight, exp.total_weight));
            if (got.entry_count !== exp.entry_count)
                report($sformatf("result %0d entry_count %0d, want %0d",
                                 result_num, got.entry_count, exp.entry_count));
            if (got.status !== exp.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 result_num, got.status, exp.status));
        endtask
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    bit             idle_on = 1'b1;
    kwat_pkg::key_t key_pool[POOL_SIZE];

    weight_table_scoreboard #(TABLE_DEPTH) sb = new;

    kwat_item_if   item_if ();
    kwat_result_if result_if ();

    keyed_weight_accumulate_table_unit #(
        .CAPACITY (TABLE_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if)
    );

    always #4 clk = ~clk;

    // Drive one item; valid stays high afterward unless the next call idles or a drain drops it
    task automatic send_item(input kwat_pkg::idx_t idx, input logic ctr,
                             input kwat_pkg::wt_t wt);
        if (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            item_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        item_if.valid      <= 1'b1;
        item_if.item_index <= idx;
        item_if.is_center  <= ctr;
        item_if.weight     <= wt;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        sb.note_item(idx, ctr, wt);
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Result side: check each transfer, stall at random
    always @(posedge clk)
    begin
        kwat_pkg::result_t got;
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            got.slot         = result_if.slot;
            got.total_weight = result_if.total_weight;
            got.entry_count  = result_if.entry_count;
            got.status       = kwat_pkg::status_t'(result_if.status);
            sb.check_result(got);
        end
        result_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: too long with no transfer on either channel
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
                (result_if.valid === 1'b1 && result_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_keyed_weight_accumulate_table_unit: errors");
        $finish;
    end

    // Stimulus
    initial
    begin
        bit             pool_seen[kwat_pkg::key_t];
        kwat_pkg::key_t k;
        kwat_pkg::wt_t  wt;
        int             window;

        rst_n              <= 1'b0;
        item_if.valid      <= 1'b0;
        item_if.item_index <= '0;
        item_if.is_center  <= 1'b0;
        item_if.weight     <= '0;

        // Key pool: edge keys first, then distinct random keys, some sharing
        // an index with the flag flipped
        key_pool[0] = {1'b0, 32'h0000_0000};
        key_pool[1] = {1'b1, 32'h0000_0000};
        key_pool[2] = {1'b0, 32'hFFFF_FFFF};
        key_pool[3] = {1'b1, 32'hFFFF_FFFF};
        key_pool[4] = {1'b0, 32'hAAAA_AAAA};
        key_pool[5] = {1'b1, 32'h5555_5555};
        for (int j = 0; j < 6; j++)
            pool_seen[key_pool[j]] = 1'b1;
        for (int j = 6; j < POOL_SIZE; j++)
        begin
            do
            begin
                if ($urandom_range(3) == 0)
                    k = {~key_pool[j-1][32], key_pool[j-1][31:0]};
                else if ($urandom_range(3) == 0)
                    k = {1'($urandom_range(1)), 32'($urandom_range(63))};
                else
                    k = {1'($urandom_range(1)), 32'($urandom)};
            end
            while (pool_seen.exists(k));
            pool_seen[k] = 1'b1;
            key_pool[j]  = k;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: edge indexes, both flags, zero/max/one weights, updates
        send_item(32'h0000_0000, 1'b0, 32'h0000_0000);
        send_item(32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 1'b0, 32'h0000_0001);
        send_item(32'hFFFF_FFFF, 1'b1, 32'h0001_0000);
        send_item(32'h0000_0000, 1'b0, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(32'hAAAA_AAAA, 1'b0, 32'h5555_5555);
        send_item(32'h5555_5555, 1'b1, 32'hAAAA_AAAA);
        send_item(32'hAAAA_AAAA, 1'b0, 32'hAAAA_AAAA);
        send_item(32'h5555_5555, 1'b1, 32'h5555_5555);
        send_item(32'h0000_0000, 1'b1, 32'h0000_0000);
        send_item(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        drain_results();

        // Max weights back to back onto slot 0: carries well into the
        // upper half of the Q32.16 total
        idle_on = 1'b0;
        for (int n = 0; n < SAT_ADDS; n++)
            send_item(32'h0000_0000, 1'b0, 32'hFFFF_FFFF);
        drain_results();
        idle_on = 1'b1;

        // Random: key window widens so early items mostly update, later ones
        // fill the table and then get dropped
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_on = !(n >= 500 && n < 700);
            window  = 40 + n / 3;
            if (window > POOL_SIZE)
                window = POOL_SIZE;
            if ($urandom_range(11) == 0)
                k = {1'($urandom_range(1)), 32'($urandom)};
            else
                k = key_pool[$urandom_range(window - 1)];
            case ($urandom_range(7))
                0:       wt = '0;
                1:       wt = '1;
                2:       wt = kwat_pkg::wt_t'($urandom_range(255));
                3:       wt = 32'h0001_0000;
                default: wt = kwat_pkg::wt_t'($urandom);
            endcase
            send_item(k[31:0], k[32], wt);
            if (n % 400 == 399)
                drain_results();
        end
        drain_results();
        idle_on = 1'b1;

        // Let any stray result show up before the verdict
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));

        if (sb.err_count == 0)
            $display("tb_keyed_weight_accumulate_table_unit: clean");
        else
            $display("tb_keyed_weight_accumulate_table_unit: errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/kwat_pkg.sv
rtl/kwat_if.sv
rtl/kwat_ram.sv
rtl/kwat_ctrl.sv
rtl/keyed_weight_accumulate_table_unit.sv
sim/tb_keyed_weight_accumulate_table_unit.sv
